// ===== rtl/manchester_frame_segment_encoder_assert.svh =====
// Assertion macros shared by the checker of the Manchester frame segment encoder.
`ifndef MANCHESTER_FRAME_SEGMENT_ENCODER_ASSERT_SVH
`define MANCHESTER_FRAME_SEGMENT_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define MFSE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mfse assertion failed");

// Next-cycle implication, disabled while reset is held.
`define MFSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mfse assertion failed");

`endif

// ===== rtl/mfse_pkg.sv =====
// Types and constants shared by the Manchester frame segment encoder modules.
`timescale 1ns / 1ps
package mfse_pkg;

    localparam int HALF_W    = 15;
    localparam int DUR_W     = 16;
    localparam int MSG_W     = 31;
    localparam int CNT_W     = 5;
    localparam int ADDR_W    = 3;
    localparam int APB_W     = 32;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;

    localparam logic [HALF_W-1:0] HALF_RESET = 15'd416;
    localparam logic              NEG_RESET  = 1'b0;

    // Register index as decoded from paddr[2].
    localparam logic REG_HALF_BIT_PERIOD = 1'b0;
    localparam logic REG_NEGATIVE_LOGIC  = 1'b1;

    typedef struct packed {
        logic [HALF_W-1:0] half;
        logic              neg;
    } t_cfg;

endpackage

// ===== rtl/mfse_cfg.sv =====
// APB-style register file holding the half-bit period and the polarity.
`timescale 1ns / 1ps
module mfse_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [mfse_pkg::ADDR_W-1:0]   i_paddr,
    input  logic [mfse_pkg::APB_W-1:0]    i_pwdata,
    output logic [mfse_pkg::APB_W-1:0]    o_prdata,
    output logic                          o_pready,
    output mfse_pkg::t_cfg                o_cfg
);

    logic [mfse_pkg::HALF_W-1:0] r_half;
    logic                        r_neg;
    logic                        w_wr;
    logic                        w_sel;

    assign o_pready = 1'b1;
    assign w_wr     = i_psel && i_penable && i_pwrite && o_pready;
    assign w_sel    = i_paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= mfse_pkg::HALF_RESET;
            r_neg  <= mfse_pkg::NEG_RESET;
        end else if (w_wr) begin
            if (w_sel == mfse_pkg::REG_HALF_BIT_PERIOD) begin
                r_half <= i_pwdata[mfse_pkg::HALF_W-1:0];
            end else begin
                r_neg <= i_pwdata[0];
            end
        end
    end

    always_comb begin
        if (w_sel == mfse_pkg::REG_NEGATIVE_LOGIC) begin
            o_prdata = {{(mfse_pkg::APB_W-1){1'b0}}, r_neg};
        end else begin
            o_prdata = {{(mfse_pkg::APB_W-mfse_pkg::HALF_W){1'b0}}, r_half};
        end
    end

    assign o_cfg.half = r_half;
    assign o_cfg.neg  = r_neg;

endmodule

// ===== rtl/mfse_core.sv =====
// Bit sequencer: walks the frame by half bits; equal adjacent halves form one segment.
`timescale 1ns / 1ps
module mfse_core #(
    parameter int MAX_DATA_BITS = 31
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mfse_pkg::t_cfg                i_cfg,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [mfse_pkg::MSG_W-1:0]    i_message,
    input  logic [mfse_pkg::CNT_W-1:0]    i_bit_count,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [mfse_pkg::DUR_W-1:0]    o_duration,
    output logic                          o_level,
    output logic                          o_last
);

    localparam int FRAME_W = MAX_DATA_BITS + 1;
    localparam int POS_W   = (FRAME_W > 2) ? $clog2(FRAME_W) : 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_FIRST  = 2'd1;
    localparam logic [1:0] ST_SECOND = 2'd2;

    logic [1:0]                   r_state, n_state;
    logic [POS_W-1:0]             r_pos, n_pos;
    logic                         r_level, n_level;
    logic                         r_out_valid, n_out_valid;
    logic [FRAME_W-1:0]           r_frame;
    logic [mfse_pkg::DUR_W-1:0]   r_out_dur;
    logic                         r_out_level;
    logic                         r_out_last;

    logic                         w_accept;
    logic                         w_step;
    logic                         w_end;
    logic                         w_merge;
    logic                         w_cur;
    logic                         w_nxt;
    logic [mfse_pkg::CNT_W-1:0]   w_n;
    logic [31:0]                  w_frame32;
    logic [mfse_pkg::DUR_W-1:0]   w_dur;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // Data bit count saturates at the configured maximum.
    assign w_n = (i_bit_count > mfse_pkg::CNT_W'(MAX_DATA_BITS))
               ? mfse_pkg::CNT_W'(MAX_DATA_BITS) : i_bit_count;

    // Start bit of 1 just above the kept message bits.
    assign w_frame32 = ({1'b0, i_message} & ~(32'hFFFF_FFFF << w_n)) | (32'd1 << w_n);

    assign w_cur  = r_frame[r_pos];
    assign w_nxt  = r_frame[r_pos - 1'b1];
    assign w_end  = (r_pos == '0);
    assign w_step = (r_state != ST_IDLE) && (!r_out_valid || i_out_ready);

    // A second half that differs from the next bit merges with that bit's first half.
    assign w_merge = (r_state == ST_SECOND) && !w_end && (w_cur != w_nxt);
    assign w_dur   = w_merge ? {i_cfg.half, 1'b0} : {1'b0, i_cfg.half};

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_level     = r_level;
        n_out_valid = r_out_valid && !i_out_ready;
        if (w_accept) begin
            n_state = ST_FIRST;
            n_pos   = w_n[POS_W-1:0];
            n_level = 1'b0;
        end
        if (w_step) begin
            n_out_valid = 1'b1;
            n_level     = ~r_level;
            case (r_state)
                ST_FIRST: begin
                    n_state = ST_SECOND;
                end
                ST_SECOND: begin
                    if (w_end) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_pos   = r_pos - 1'b1;
                        n_state = w_merge ? ST_SECOND : ST_FIRST;
                    end
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_level     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_level     <= n_level;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_frame <= w_frame32[FRAME_W-1:0];
        end
        if (w_step) begin
            r_out_dur   <= w_dur;
            r_out_level <= r_level ^ i_cfg.neg;
            r_out_last  <= (r_state == ST_SECOND) && w_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_duration  = r_out_dur;
    assign o_level     = r_out_level;
    assign o_last      = r_out_last;

endmodule

// ===== rtl/manchester_frame_segment_encoder.sv =====
// Top level of the Manchester frame segment encoder: register file, sequencer and ports.
// An accepted item first moves the sequencer state out of idle; the first segment then comes from the output register.
// Throughput: one segment per cycle while the output is taken, n+2 to 2*(n+1) segments for
// n data bits; a frame keeps the input closed until its last segment is loaded for output.
// The sequencer's single bit-pair compare and output register set this rate.
// Reset is synchronous and active low; registers return to 416 and positive logic.
`timescale 1ns / 1ps
module manchester_frame_segment_encoder #(
    parameter int MAX_DATA_BITS = 31
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [30:0] message, [35:31] bit_count, [39:36] zero
    input  logic [mfse_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [15:0] segment_duration, [16] line_level, [23:17] zero
    output logic [mfse_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    output logic                             o_m_axis_tlast,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mfse_pkg::ADDR_W-1:0]      paddr,
    input  logic [mfse_pkg::APB_W-1:0]       pwdata,
    output logic [mfse_pkg::APB_W-1:0]       prdata,
    output logic                             pready
);

    mfse_pkg::t_cfg                w_cfg;
    logic [mfse_pkg::DUR_W-1:0]    w_dur;
    logic                          w_level;

    mfse_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (w_cfg)
    );

    mfse_core #(
        .MAX_DATA_BITS (MAX_DATA_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_message   (i_s_axis_tdata[mfse_pkg::MSG_W-1:0]),
        .i_bit_count (i_s_axis_tdata[mfse_pkg::MSG_W+mfse_pkg::CNT_W-1:mfse_pkg::MSG_W]),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_duration  (w_dur),
        .o_level     (w_level),
        .o_last      (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {{(mfse_pkg::M_TDATA_W-mfse_pkg::DUR_W-1){1'b0}}, w_level, w_dur};

endmodule

// ===== rtl/mfse_chk.sv =====
// Port-level checker for the Manchester frame segment encoder, bound to the top level.
`timescale 1ns / 1ps
`include "manchester_frame_segment_encoder_assert.svh"
module mfse_chk (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    input  logic [mfse_pkg::M_TDATA_W-1:0]   i_m_tdata,
    input  logic                             i_m_tlast
);

    // A held segment must not change while the sink stalls.
    `MFSE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tlast))

    // An accepted frame keeps the input closed while it is being sent.
    `MFSE_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_s_tvalid && i_s_tready, !i_s_tready)

    // A pending segment that is not the last means the frame is still in progress.
    `MFSE_ASSERT_IMP(a_mid_frame_busy, i_clk, i_rst_n, i_m_tvalid && !i_m_tlast, !i_s_tready)

    // The padding above the line level is always zero.
    `MFSE_ASSERT_IMP(a_pad_zero, i_clk, i_rst_n, i_m_tvalid, i_m_tdata[mfse_pkg::M_TDATA_W-1:mfse_pkg::DUR_W+1] == '0)

endmodule

bind manchester_frame_segment_encoder mfse_chk u_mfse_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_axis_tvalid),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tlast  (o_m_axis_tlast)
);
